// File: rtl/core/srrip_pkg.sv
// Shared types and constants for the SRRIP replacement state block.
`timescale 1ns / 1ps

package srrip_pkg;

    localparam int CMD_W = 2;
    localparam int SET_W = 10;
    localparam int WAY_W = 4;

    typedef logic [1:0] t_rrpv;
    typedef logic [CMD_W-1:0] t_cmd;

    localparam t_cmd CMD_HIT    = 2'd0;
    localparam t_cmd CMD_INSERT = 2'd1;
    localparam t_cmd CMD_VICTIM = 2'd2;

    localparam t_rrpv RRPV_NEAR    = 2'd0;
    localparam t_rrpv RRPV_LONG    = 2'd2;
    localparam t_rrpv RRPV_DISTANT = 2'd3;

endpackage

// File: rtl/core/srrip_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module srrip_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/srrip_replacement_policy.sv
// Top level of the SRRIP replacement state block: sequencer, row update and result register.
`timescale 1ns / 1ps

// SRRIP replacement state. Each set keeps a 2-bit re-reference prediction
// value per way in one row of a single RAM. A request carries a command
// (hit, insert, victim), a set index and a way. Hit writes 0 to the way,
// insert writes 2, victim returns the lowest way holding 3, aging the whole
// set first when no way holds 3. Every request produces exactly one result;
// victim_valid is set only for a victim request to a set below NUM_SETS.
// The accept cycle issues the row read; the update state then modifies the
// row, writes it back and loads the result register once that register is
// free. No new request is taken until this row read-modify-write is done.
// The result register lets a new request enter while the previous result is
// stalled; a second result waits in the update cycle until the register frees.
// After reset the block clears all min(NUM_SETS, 1024) rows to 3 in every way,
// one row a cycle, and holds o_stall high meanwhile.
module srrip_replacement_policy
    import srrip_pkg::*;
#(
    parameter int NUM_WAYS = 16,
    parameter int NUM_SETS = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [CMD_W-1:0] i_cmd,
    input  logic [SET_W-1:0] i_set_index,
    input  logic [WAY_W-1:0] i_way_index,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [WAY_W-1:0] o_victim_way,
    output logic             o_victim_valid
);

    // Only sets reachable through the 10-bit index need storage.
    localparam int MAX_ROWS  = 1 << SET_W;
    localparam int ROWS      = (NUM_SETS < MAX_ROWS) ? NUM_SETS : MAX_ROWS;
    localparam int AW        = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int ROW_W     = 2 * NUM_WAYS;
    localparam int WAY_NUM_W = $clog2(NUM_WAYS);
    localparam int EXT_W     = (WAY_NUM_W > WAY_W) ? WAY_NUM_W : WAY_W;
    localparam int RANGE_W   = 17;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;

    logic [1:0]    r_state, n_state;
    logic [AW-1:0] r_clr_addr;
    logic          r_out_valid;

    // Request captured at accept.
    t_cmd          r_cmd;
    logic [WAY_W-1:0] r_way;
    logic [AW-1:0] r_addr;
    logic          r_in_range;

    logic [WAY_W-1:0] r_victim_way;
    logic          r_victim_valid;

    logic          in_accept;
    logic          can_out;
    logic          exec_done;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [ROW_W-1:0] ram_wdata;
    logic [ROW_W-1:0] row_rd;
    logic [ROW_W-1:0] row_upd;
    logic [ROW_W-1:0] row_aged;

    t_rrpv         top;
    t_rrpv         age_add;
    logic          any3, any2, any1;
    logic [WAY_NUM_W-1:0] victim_idx;
    logic [EXT_W-1:0] victim_ext;

    assign in_accept = i_valid && !o_stall;
    assign o_stall   = (r_state != S_IDLE);
    assign can_out   = !r_out_valid || !i_stall;
    assign exec_done = (r_state == S_EXEC) && can_out;

    // Sequencer: clear sweep, then idle / update alternation.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == AW'(ROWS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (can_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (exec_done) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture the request, folding the set compare into one flag; load the result at update.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cmd      <= i_cmd;
            r_way      <= i_way_index;
            r_addr     <= i_set_index[AW-1:0];
            r_in_range <= (RANGE_W'(i_set_index) < RANGE_W'(NUM_SETS));
        end
        if (exec_done) begin
            r_victim_way   <= (r_in_range && (r_cmd == CMD_VICTIM)) ?
                              victim_ext[WAY_W-1:0] : '0;
            r_victim_valid <= r_in_range && (r_cmd == CMD_VICTIM);
        end
    end

    // Largest value in the row: bit tests over the ways.
    always_comb begin
        any3 = 1'b0;
        any2 = 1'b0;
        any1 = 1'b0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            any3 = any3 | (row_rd[2*w +: 2] == RRPV_DISTANT);
            any2 = any2 | (row_rd[2*w +: 2] == RRPV_LONG);
            any1 = any1 | (row_rd[2*w +: 2] == 2'd1);
        end
        if (any3) begin
            top = RRPV_DISTANT;
        end else if (any2) begin
            top = RRPV_LONG;
        end else if (any1) begin
            top = 2'd1;
        end else begin
            top = RRPV_NEAR;
        end
        age_add = RRPV_DISTANT - top;
    end

    // Age every way and pick the lowest way that holds the largest value,
    // which is the lowest way at 3 after aging.
    always_comb begin
        victim_idx = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            row_aged[2*w +: 2] = row_rd[2*w +: 2] + age_add;
            if (row_rd[2*w +: 2] == top) begin
                victim_idx = WAY_NUM_W'(w);
            end
        end
        victim_ext = EXT_W'(victim_idx);
    end

    // Promote or insert the named way; a way beyond the set matches nothing.
    always_comb begin
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (EXT_W'(r_way) == EXT_W'(w)) begin
                row_upd[2*w +: 2] = (r_cmd == CMD_HIT) ? RRPV_NEAR : RRPV_LONG;
            end else begin
                row_upd[2*w +: 2] = row_rd[2*w +: 2];
            end
        end
    end

    // Write port: clear sweep, or write back the modified row.
    always_comb begin
        if (r_state == S_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = {NUM_WAYS{RRPV_DISTANT}};
        end else begin
            ram_we    = exec_done && r_in_range &&
                        ((r_cmd == CMD_HIT) || (r_cmd == CMD_INSERT) ||
                         (r_cmd == CMD_VICTIM));
            ram_waddr = r_addr;
            ram_wdata = (r_cmd == CMD_VICTIM) ? row_aged : row_upd;
        end
    end

    srrip_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ROWS),
        .ADDR_W(AW)
    ) u_rrpv_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (in_accept),
        .i_raddr(i_set_index[AW-1:0]),
        .o_rdata(row_rd)
    );

    assign o_valid        = r_out_valid;
    assign o_victim_way   = r_victim_way;
    assign o_victim_valid = r_victim_valid;

    // A row read never overlaps a write-back or the clear sweep.
    a_no_rd_wr_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |-> !ram_we)
        else $error("row read issued while a write is in flight");

    // A new result appears only from the update cycle.
    a_result_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ($past(r_state) == S_EXEC))
        else $error("result appeared outside the update cycle");

    // A request is followed by its update cycle.
    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == S_EXEC))
        else $error("accepted request did not enter the update cycle");

    // A non-victim result carries way zero.
    a_idle_way_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_victim_valid) |-> (o_victim_way == '0))
        else $error("non-victim result carries a nonzero way");

endmodule
